FILE: src/ncdf_pkg.sv
// Shared constants, latencies and types of the normal density and distribution pipeline.
package ncdf_pkg;

   localparam int QB = 30;
   localparam logic [30:0] Q_ONE = 31'h4000_0000;
   localparam logic [29:0] Q_HALF = 30'h2000_0000;

   localparam logic [27:0] C_GAMMA = 28'd248723596;
   localparam logic [29:0] C_LN2 = 30'd744261118;
   localparam logic [28:0] C_INV_SQRT_2PI = 29'd428361012;
   localparam logic signed [32:0] C_A5 = 33'sd1428371292;

   localparam int POLY_ORDER = 5;
   localparam logic signed [32:0] POLY_ADD [0:POLY_ORDER-1] = '{
      -33'sd1955558716, 33'sd1912847369, -33'sd382857446, 33'sd342933307, 33'sd0};

   localparam int TAYLOR_TERMS = 13;
   localparam int LN2_QBITS = 6;
   localparam int RECIP_QBITS = 31;

   localparam int LAT_EXP = LN2_QBITS + 3 * TAYLOR_TERMS + 4;
   localparam int LAT_RECIP = RECIP_QBITS;
   localparam int LAT_POLY = 2 * POLY_ORDER + 1;

   typedef struct packed {
      logic [30:0] term;
      logic [30:0] sum;
      logic [29:0] r;
      logic [5:0]  n;
      logic        cut;
   } taylor_type;

endpackage

FILE: src/ncdf_taylor_step.sv
// One term of the exponential series: multiply by r, round, divide by the term index.
module ncdf_taylor_step #(
   parameter int IDX = 1
) (
   input  logic                   clock,
   input  ncdf_pkg::taylor_type   step_i,
   output ncdf_pkg::taylor_type   step_o
);

   localparam int SHR = 31 + $clog2(IDX);
   localparam logic [32:0] MUL = 33'(((64'd1 << SHR) + 64'(IDX) - 64'd1) / 64'(IDX));
   localparam bit USE_PREV = (IDX > 1);
   localparam bit SUB_PREV = (((IDX - 1) % 2) == 1);

   ncdf_pkg::taylor_type ctl1_ff, ctl2_ff, ctl3_ff;
   ncdf_pkg::taylor_type ctl1_in;
   logic [30:0] sum1_in;
   logic [60:0] p1_ff;
   logic [30:0] t2_ff;
   logic [63:0] d3_ff;

   always_comb begin
      sum1_in = step_i.sum;
      if (USE_PREV) begin
         if (SUB_PREV) begin
            sum1_in = step_i.sum - step_i.term;
         end else begin
            sum1_in = step_i.sum + step_i.term;
         end
      end
   end

   always_comb begin
      ctl1_in     = step_i;
      ctl1_in.sum = sum1_in;
   end

   always_ff @(posedge clock) begin
      ctl1_ff     <= ctl1_in;
      p1_ff       <= 61'(step_i.term) * 61'(step_i.r);
      ctl2_ff     <= ctl1_ff;
      t2_ff       <= 31'((p1_ff + 61'(ncdf_pkg::Q_HALF)) >> ncdf_pkg::QB);
      ctl3_ff     <= ctl2_ff;
      d3_ff       <= 64'(t2_ff) * 64'(MUL);
   end

   always_comb begin
      step_o      = ctl3_ff;
      step_o.term = 31'(d3_ff >> SHR);
   end

endmodule

FILE: src/ncdf_exp.sv
// Density path: range reduction by ln2, exponential series, scaling by 1/sqrt(2*pi).
module ncdf_exp (
   input  logic        clock,
   input  logic [34:0] y,
   input  logic        cut,
   output logic [29:0] pdf
);

   logic [34:0] rem_ff [0:ncdf_pkg::LN2_QBITS-1];
   logic [5:0]  q_ff   [0:ncdf_pkg::LN2_QBITS-1];
   logic        cut_ff [0:ncdf_pkg::LN2_QBITS-1];

   for (genvar j = 0; j < ncdf_pkg::LN2_QBITS; j++) begin : g_div
      localparam int B = ncdf_pkg::LN2_QBITS - 1 - j;
      localparam logic [34:0] DIVS = 35'(ncdf_pkg::C_LN2) << B;
      logic [34:0] rem_src, rem_in;
      logic [5:0]  q_src, q_in;
      logic        cut_src;
      if (j == 0) begin : g_first
         assign rem_src = y;
         assign q_src   = '0;
         assign cut_src = cut;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign cut_src = cut_ff[j-1];
      end
      always_comb begin
         rem_in = rem_src;
         q_in   = q_src;
         if (rem_src >= DIVS) begin
            rem_in  = rem_src - DIVS;
            q_in[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         q_ff[j]   <= q_in;
         cut_ff[j] <= cut_src;
      end
   end

   ncdf_pkg::taylor_type chain [0:ncdf_pkg::TAYLOR_TERMS];

   always_comb begin
      chain[0].term = ncdf_pkg::Q_ONE;
      chain[0].sum  = ncdf_pkg::Q_ONE;
      chain[0].r    = rem_ff[ncdf_pkg::LN2_QBITS-1][29:0];
      chain[0].n    = q_ff[ncdf_pkg::LN2_QBITS-1];
      chain[0].cut  = cut_ff[ncdf_pkg::LN2_QBITS-1];
   end

   for (genvar i = 1; i <= ncdf_pkg::TAYLOR_TERMS; i++) begin : g_term
      ncdf_taylor_step #(.IDX(i)) u_step (
         .clock  (clock),
         .step_i (chain[i-1]),
         .step_o (chain[i])
      );
   end

   localparam bit LAST_SUB = ((ncdf_pkg::TAYLOR_TERMS % 2) == 1);

   logic [30:0] sum_ff, sum_in;
   logic [5:0]  n_ff;
   logic        cutf_ff;
   logic [30:0] e_ff, e_in;
   logic [59:0] prod_ff;
   logic [29:0] pdf_ff;

   always_comb begin
      if (LAST_SUB) begin
         sum_in = chain[ncdf_pkg::TAYLOR_TERMS].sum - chain[ncdf_pkg::TAYLOR_TERMS].term;
      end else begin
         sum_in = chain[ncdf_pkg::TAYLOR_TERMS].sum + chain[ncdf_pkg::TAYLOR_TERMS].term;
      end
   end

   always_comb begin
      if (cutf_ff) begin
         e_in = '0;
      end else if (n_ff == 6'd0) begin
         e_in = sum_ff;
      end else begin
         e_in = 31'((64'(sum_ff) + (64'd1 << (n_ff - 6'd1))) >> n_ff);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      n_ff    <= chain[ncdf_pkg::TAYLOR_TERMS].n;
      cutf_ff <= chain[ncdf_pkg::TAYLOR_TERMS].cut;
      e_ff    <= e_in;
      prod_ff <= 60'(e_ff) * 60'(ncdf_pkg::C_INV_SQRT_2PI);
      pdf_ff  <= 30'((prod_ff + 60'(ncdf_pkg::Q_HALF)) >> ncdf_pkg::QB);
   end

   assign pdf = pdf_ff;

endmodule

FILE: src/ncdf_recip.sv
// Pipelined restoring divider that forms k = round(2^60 / denom), one quotient bit per stage.
module ncdf_recip #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic [DW-1:0] denom,
   output logic [30:0]   k
);

   localparam int NQ = ncdf_pkg::RECIP_QBITS;

   logic [DW-1:0] rem_ff [0:NQ-1];
   logic [DW-1:0] den_ff [0:NQ-1];
   logic [30:0]   low_ff [0:NQ-1];
   logic [30:0]   q_ff   [0:NQ-1];

   for (genvar j = 0; j < NQ; j++) begin : g_stage
      localparam int B = NQ - 1 - j;
      logic [DW-1:0] rem_src, den_src, rem_in;
      logic [30:0]   low_src, q_src, q_in;
      logic [DW:0]   sh;
      if (j == 0) begin : g_first
         assign rem_src = DW'(denom >> 32) + (DW'(1) << 29);
         assign den_src = denom;
         assign low_src = 31'(denom >> 1);
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign low_src = low_ff[j-1];
         assign q_src   = q_ff[j-1];
      end
      always_comb begin
         sh     = {rem_src, low_src[B]};
         rem_in = DW'(sh);
         q_in   = q_src;
         if (sh >= {1'b0, den_src}) begin
            rem_in  = DW'(sh - {1'b0, den_src});
            q_in[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_src;
         low_ff[j] <= low_src;
         q_ff[j]   <= q_in;
      end
   end

   assign k = q_ff[NQ-1];

endmodule

FILE: src/ncdf_poly.sv
// Horner evaluation of the five-term tail polynomial in k, clamped to [0, 1].
module ncdf_poly (
   input  logic        clock,
   input  logic [30:0] k,
   output logic [30:0] tailf
);

   localparam int NP = ncdf_pkg::POLY_ORDER;

   logic [62:0]        prod_ff [0:NP-1];
   logic               sgn_ff  [0:NP-1];
   logic [30:0]        ka_ff   [0:NP-1];
   logic signed [32:0] t_ff    [0:NP-1];
   logic [30:0]        kb_ff   [0:NP-1];

   for (genvar s = 0; s < NP; s++) begin : g_horner
      logic signed [32:0] t_src, t_in;
      logic [30:0]        k_src;
      logic [31:0]        mag;
      logic signed [32:0] p;
      if (s == 0) begin : g_first
         assign t_src = ncdf_pkg::C_A5;
         assign k_src = k;
      end else begin : g_next
         assign t_src = t_ff[s-1];
         assign k_src = kb_ff[s-1];
      end
      always_comb begin
         mag = t_src[32] ? 32'(-t_src) : 32'(t_src);
         p   = $signed(33'((prod_ff[s] + 63'(ncdf_pkg::Q_HALF)) >> ncdf_pkg::QB));
         if (sgn_ff[s]) begin
            t_in = ncdf_pkg::POLY_ADD[s] - p;
         end else begin
            t_in = ncdf_pkg::POLY_ADD[s] + p;
         end
      end
      always_ff @(posedge clock) begin
         prod_ff[s] <= 63'(mag) * 63'(k_src);
         sgn_ff[s]  <= t_src[32];
         ka_ff[s]   <= k_src;
         t_ff[s]    <= t_in;
         kb_ff[s]   <= ka_ff[s];
      end
   end

   logic [30:0] tailf_ff, tailf_in;

   always_comb begin
      if (t_ff[NP-1][32]) begin
         tailf_in = '0;
      end else if ($unsigned(t_ff[NP-1]) > 33'(ncdf_pkg::Q_ONE)) begin
         tailf_in = ncdf_pkg::Q_ONE;
      end else begin
         tailf_in = t_ff[NP-1][30:0];
      end
   end

   always_ff @(posedge clock) begin
      tailf_ff <= tailf_in;
   end

   assign tailf = tailf_ff;

endmodule

FILE: src/normal_cdf_and_pdf_core.sv
// Top level: standard normal density and cumulative distribution, one point per cycle.
//
//   Channel   Ports                               Transfer
//   request   start, busy, req_point              start high while busy is low
//   response  rsp_strobe, rsp_cdf_value,          rsp_strobe high for one cycle
//             rsp_pdf_value
//
// A point can enter on every cycle.
// The latency is set by the density path: four input stages, a six-stage ln2 reduction,
// 13 series terms of three stages each, four stages of rounding and scaling, and four
// output stages. The 31-stage reciprocal divider and the 11-stage Horner chain run beside
// it and are delayed through a register delay line to match.
// Reset clears only the valid bits of the pipeline; data registers hold no reset.
// busy never rises, and the receiver cannot stall, so the pipeline advances every cycle.
module normal_cdf_and_pdf_core #(
   parameter int IN_FRAC_BITS = 12,
   parameter int OUT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [15:0]         req_point,
   output logic                rsp_strobe,
   output logic [OUT_BITS-1:0] rsp_cdf_value,
   output logic [OUT_BITS-1:0] rsp_pdf_value
);

   localparam int SH = 29 - 2 * IN_FRAC_BITS;
   localparam int YW = 31 + ((SH > 0) ? SH : 0);
   localparam int YX = (YW > 36) ? YW : 36;
   localparam int DW = ((43 - IN_FRAC_BITS > 30) ? 43 - IN_FRAC_BITS : 30) + 1;
   localparam int TAIL_LAT = ncdf_pkg::LAT_RECIP + ncdf_pkg::LAT_POLY;
   localparam int ALIGN = (ncdf_pkg::LAT_EXP > TAIL_LAT) ? ncdf_pkg::LAT_EXP : TAIL_LAT;
   localparam int D_T = ALIGN - TAIL_LAT;
   localparam int D_P = ALIGN - ncdf_pkg::LAT_EXP;
   localparam int TOTAL = ALIGN + 8;
   localparam int OW = 31 + OUT_BITS;

   logic [TOTAL-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TOTAL-2:0], start};
      end
   end

   assign busy = 1'b0;

   logic [15:0]   pt_ff;
   logic [15:0]   m_ff;
   logic          neg1_ff, neg2_ff, neg3_ff;
   logic [30:0]   sq_ff;
   logic [43:0]   g_ff;
   logic [YW-1:0] y_ff, y_in;
   logic          cut_ff, cut_in;
   logic [DW-1:0] denom_ff, denom_in;

   if (SH >= 0) begin : g_yexact
      assign y_in = YW'(sq_ff) << SH;
   end else begin : g_yround
      localparam int RS = -SH;
      assign y_in = YW'((32'(sq_ff) + (32'(1) << (RS - 1))) >> RS);
   end

   assign cut_in = (YX'(y_in) >= (YX'(1) << 35));
   assign denom_in = DW'((44'(g_ff) + (44'(1) << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS)
                   + (DW'(1) << 30);

   always_ff @(posedge clock) begin
      pt_ff    <= req_point;
      neg1_ff  <= pt_ff[15];
      m_ff     <= pt_ff[15] ? 16'(17'h10000 - {1'b0, pt_ff}) : pt_ff;
      neg2_ff  <= neg1_ff;
      sq_ff    <= 31'(32'(m_ff) * 32'(m_ff));
      g_ff     <= 44'(m_ff) * 44'(ncdf_pkg::C_GAMMA);
      neg3_ff  <= neg2_ff;
      y_ff     <= y_in;
      cut_ff   <= cut_in;
      denom_ff <= denom_in;
   end

   logic [29:0] pdf_raw, pdf_al;
   logic [30:0] k, tailf, tailf_al;

   ncdf_exp u_exp (
      .clock (clock),
      .y     (35'(y_ff)),
      .cut   (cut_ff),
      .pdf   (pdf_raw)
   );

   ncdf_recip #(.DW(DW)) u_recip (
      .clock (clock),
      .denom (denom_ff),
      .k     (k)
   );

   ncdf_poly u_poly (
      .clock (clock),
      .k     (k),
      .tailf (tailf)
   );

   if (D_T > 0) begin : g_tdelay
      logic [30:0] tdl_ff [0:D_T-1];
      always_ff @(posedge clock) begin
         tdl_ff[0] <= tailf;
         for (int i = 1; i < D_T; i++) begin
            tdl_ff[i] <= tdl_ff[i-1];
         end
      end
      assign tailf_al = tdl_ff[D_T-1];
   end else begin : g_tdirect
      assign tailf_al = tailf;
   end

   if (D_P > 0) begin : g_pdelay
      logic [29:0] pdl_ff [0:D_P-1];
      always_ff @(posedge clock) begin
         pdl_ff[0] <= pdf_raw;
         for (int i = 1; i < D_P; i++) begin
            pdl_ff[i] <= pdl_ff[i-1];
         end
      end
      assign pdf_al = pdl_ff[D_P-1];
   end else begin : g_pdirect
      assign pdf_al = pdf_raw;
   end

   logic ndl_ff [0:ALIGN-1];

   always_ff @(posedge clock) begin
      ndl_ff[0] <= neg3_ff;
      for (int i = 1; i < ALIGN; i++) begin
         ndl_ff[i] <= ndl_ff[i-1];
      end
   end

   logic [60:0]         prod_ff;
   logic [29:0]         pdfa_ff, pdfb_ff, pdfc_ff;
   logic                nega_ff, negb_ff;
   logic [30:0]         tail_ff, tail_in, tail_rnd;
   logic [30:0]         cdf_ff, cdf_in;
   logic [OW-1:0]       cdf_wide, pdf_wide;
   logic [OUT_BITS:0]   cdf_o, pdf_o;
   logic [OUT_BITS-1:0] cdfo_ff, pdfo_ff;

   always_comb begin
      tail_rnd = 31'((prod_ff + 61'(ncdf_pkg::Q_HALF)) >> ncdf_pkg::QB);
      tail_in  = (tail_rnd > ncdf_pkg::Q_ONE) ? ncdf_pkg::Q_ONE : tail_rnd;
      cdf_in   = negb_ff ? tail_ff : ncdf_pkg::Q_ONE - tail_ff;
      cdf_wide = (OW'(cdf_ff) << OUT_BITS) + (OW'(1) << 29);
      pdf_wide = (OW'(pdfc_ff) << OUT_BITS) + (OW'(1) << 29);
      cdf_o    = (OUT_BITS + 1)'(cdf_wide >> ncdf_pkg::QB);
      pdf_o    = (OUT_BITS + 1)'(pdf_wide >> ncdf_pkg::QB);
   end

   always_ff @(posedge clock) begin
      prod_ff <= 61'(tailf_al) * 61'(pdf_al);
      pdfa_ff <= pdf_al;
      nega_ff <= ndl_ff[ALIGN-1];
      tail_ff <= tail_in;
      pdfb_ff <= pdfa_ff;
      negb_ff <= nega_ff;
      cdf_ff  <= cdf_in;
      pdfc_ff <= pdfb_ff;
      cdfo_ff <= cdf_o[OUT_BITS] ? '1 : cdf_o[OUT_BITS-1:0];
      pdfo_ff <= pdf_o[OUT_BITS] ? '1 : pdf_o[OUT_BITS-1:0];
   end

   assign rsp_strobe    = vld_ff[TOTAL-1];
   assign rsp_cdf_value = cdfo_ff;
   assign rsp_pdf_value = pdfo_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##TOTAL rsp_strobe)
      else $error("result did not appear at the pipeline latency");

   a_pdf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_pdf_value[OUT_BITS-1])
      else $error("density exceeds one half");

   a_tail_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ALIGN+3] |-> (tailf_al <= ncdf_pkg::Q_ONE))
      else $error("tail factor outside the unit range");
`endif

endmodule

FILE: bench/normal_cdf_and_pdf_checker.sv
// Checker for the normal density and distribution core: predicts each result and compares it.
module normal_cdf_and_pdf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_point,
   input  logic        rsp_strobe,
   input  logic [15:0] rsp_cdf_value,
   input  logic [15:0] rsp_pdf_value,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64;

   typedef struct packed {
      logic [15:0] cdf;
      logic [15:0] pdf;
   } normal_pair_type;

   localparam u64 ONE = 64'd1 << 30;
   localparam u64 HALF = 64'd1 << 29;
   localparam u64 GAMMA = 64'd248723596;
   localparam u64 LN2 = 64'd744261118;
   localparam u64 INV_SQRT_2PI = 64'd428361012;
   localparam longint COEF_A1 = 342933307;
   localparam longint COEF_A2 = -382857446;
   localparam longint COEF_A3 = 1912847369;
   localparam longint COEF_A4 = -1955558716;
   localparam longint COEF_A5 = 1428371292;

   normal_pair_type expected_pairs [$];

   function automatic u64 qmul(u64 a, u64 b);
      return (a * b + HALF) >> 30;
   endfunction

   function automatic longint qmul_signed(longint a, u64 b);
      u64 mag;
      longint p;
      mag = (a < 0) ? u64'(-a) : u64'(a);
      p = longint'(qmul(mag, b));
      return (a < 0) ? -p : p;
   endfunction

   function automatic u64 exp_of_negative(u64 y);
      u64 n, r, sum, term;
      if (y >= (64'd32 << 30)) return 0;
      n = y / LN2;
      r = y - n * LN2;
      sum = ONE;
      term = ONE;
      for (int i = 1; i <= 13; i++) begin
         term = qmul(term, r) / u64'(i);
         if (i % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      if (n == 0) return sum;
      return (sum + (64'd1 << (n - 1))) >> n;
   endfunction

   function automatic logic [15:0] to_q16(u64 v);
      u64 o;
      o = ((v << 16) + HALF) >> 30;
      return (o > 64'd65535) ? 16'hFFFF : o[15:0];
   endfunction

   function automatic normal_pair_type normal_at(logic [15:0] point);
      logic neg;
      u64 m, y, e, pdf, ax, denom, k, tailf, tail, cdf;
      longint t;
      normal_pair_type res;
      neg = point[15];
      m = neg ? (64'h10000 - u64'(point)) : u64'(point);
      y = (m * m) << 5;
      e = exp_of_negative(y);
      pdf = qmul(e, INV_SQRT_2PI);
      ax = m << 18;
      denom = ONE + qmul(GAMMA, ax);
      k = ((64'd1 << 60) + denom / 2) / denom;
      t = COEF_A5;
      t = qmul_signed(t, k) + COEF_A4;
      t = qmul_signed(t, k) + COEF_A3;
      t = qmul_signed(t, k) + COEF_A2;
      t = qmul_signed(t, k) + COEF_A1;
      t = qmul_signed(t, k);
      if (t < 0) t = 0;
      tailf = u64'(t);
      if (tailf > ONE) tailf = ONE;
      tail = qmul(tailf, pdf);
      if (tail > ONE) tail = ONE;
      cdf = neg ? tail : ONE - tail;
      res.cdf = to_q16(cdf);
      res.pdf = to_q16(pdf);
      return res;
   endfunction

   assign pending = expected_pairs.size();

   initial failures = 0;

   always @(posedge clock) begin
      normal_pair_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_pairs.size() == 0) begin
               failures <= failures + 1;
               $display("%0t: unexpected transfer cdf=%h pdf=%h", $time,
                        rsp_cdf_value, rsp_pdf_value);
            end else begin
               want = expected_pairs.pop_front();
               if (want.cdf !== rsp_cdf_value || want.pdf !== rsp_pdf_value) begin
                  failures <= failures + 1;
                  $display("%0t: expected cdf=%h pdf=%h, actual cdf=%h pdf=%h", $time,
                           want.cdf, want.pdf, rsp_cdf_value, rsp_pdf_value);
               end
            end
         end
         if (start && !busy) expected_pairs.push_back(normal_at(req_point));
      end
   end
endmodule

FILE: bench/normal_cdf_and_pdf_core_test.sv
// Testbench top: drives points into the normal density and distribution core and reports.
module normal_cdf_and_pdf_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_POINTS = 830;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_point;
   logic        rsp_strobe;
   logic [15:0] rsp_cdf_value;
   logic [15:0] rsp_pdf_value;
   int          failures;
   int          pending;
   int          idle_cycles;

   normal_cdf_and_pdf_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_point(req_point),
      .rsp_strobe(rsp_strobe), .rsp_cdf_value(rsp_cdf_value), .rsp_pdf_value(rsp_pdf_value)
   );

   normal_cdf_and_pdf_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_point(req_point),
      .rsp_strobe(rsp_strobe), .rsp_cdf_value(rsp_cdf_value), .rsp_pdf_value(rsp_pdf_value),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("normal_cdf_and_pdf_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_point(logic [15:0] value, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_point <= value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_point();
      case ($urandom_range(0, 3))
         0: return 16'($signed($urandom_range(0, 8191)) - 4096);
         1: return 16'($signed($urandom_range(0, 65535)) - 32768);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      logic [15:0] directed [] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
         16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000, 16'h6000,
         16'hA000, 16'h7000, 16'h9000, 16'h0800, 16'hF800, 16'h5555, 16'hAAAA,
         16'h0010, 16'hFFF0, 16'h8001, 16'h7FFE};
      bit steady;
      start = 1'b0;
      req_point = 16'h0000;
      reset = 1'b1;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_point(directed[i], (i % 3 == 0) ? $urandom_range(0, 17) : 0);
      steady = 1'b0;
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         if (i % 60 == 0) steady = ($urandom_range(0, 2) == 0);
         if (i == RANDOM_POINTS / 2) begin
            start <= 1'b0;
            wait (pending == 0);
            @(posedge clock);
         end
         send_point(random_point(), steady ? 0 : $urandom_range(0, 17));
      end
      start <= 1'b0;
      wait (pending == 0);
      repeat (80) @(posedge clock);
      if (failures == 0) begin
         $display("normal_cdf_and_pdf_core: match");
      end else begin
         $display("normal_cdf_and_pdf_core: mismatch");
      end
      $finish;
   end
endmodule
